// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the URL percent decoder RTL.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/urlpd_pkg.sv
// Types, constants and helper functions of the URL percent decoder.
// No dependencies; used by urlpd_step and url_percent_decoder_core.
package urlpd_pkg;

  localparam int ADDR_W         = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int FIFO_DEPTH_DEF = 4;

  localparam logic [15:0] CAP_RESET  = 16'd1024;
  localparam logic        REG_CAPACITY = 1'b0;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] DIGIT_BAD  = 8'hFF;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PCT,
    PH_DIG
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  held;
    logic [15:0] count;
    logic        stopped;
  } dec_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [1:0] num;
    item_t      item0;
    item_t      item1;
  } step_res_t;

  localparam dec_state_t STATE_CLEAR = '{phase: PH_IDLE, held: 8'h00,
                                         count: 16'h0000, stopped: 1'b0};
  localparam item_t ITEM_TERM = '{data: CHAR_NUL, last: 1'b1};
  localparam item_t ITEM_NONE = '{data: CHAR_NUL, last: 1'b0};

  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = c - 8'h61 + 8'd10;
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      v = c - 8'h41 + 8'd10;
    end else begin
      v = DIGIT_BAD;
    end
    return v;
  endfunction

  function automatic logic [7:0] plain_char(input logic [7:0] c);
    return (c == CHAR_PLUS) ? CHAR_SPACE : c;
  endfunction

endpackage

// File: hw/rtl/url_percent_decoder_core.sv
// Top level of the URL percent decoder: input register, decode step, result
// queue and capacity register. Depends on urlpd_pkg, urlpd_step, assert_macros.svh.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  input   | in_valid, in_stall, in_byte             | in
//  result  | out_valid, out_stall, out_byte, out_last| out
//  config  | psel, penable, pwrite, paddr, pwdata,   | APB
//          | prdata, pready                          |
//
// One item per cycle sustained while the queue has room: a byte is held in the input register,
// is decoded there and its zero to two results land in the queue.
// The first result is visible once the byte has been decoded and written into the queue.
// The input register holds while the queue lacks room for two results, which
// is the only source of in_stall. Reset is synchronous and clears all control
// state; capacity resets to 1024.
module url_percent_decoder_core #(
  parameter int FIFO_DEPTH = urlpd_pkg::FIFO_DEPTH_DEF  // power of two, at least 2
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       out_byte,
  output logic                             out_last,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [urlpd_pkg::ADDR_W-1:0]     paddr,
  input  logic [urlpd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [urlpd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                             pready
);
  import urlpd_pkg::*;

  `include "assert_macros.svh"

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [CNT_W-1:0] ROOM_LIM = CNT_W'(FIFO_DEPTH - 2);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(FIFO_DEPTH);

  logic             in_vld_r, in_vld_nxt;
  logic [7:0]       in_byte_r;
  dec_state_t       st_r, st_nxt;
  step_res_t        res;
  logic [15:0]      cap_r;
  item_t            mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             room;
  logic             proc;
  logic             in_acc;
  logic             pop;
  logic             cfg_wr;
  item_t            head;

  // --- configuration ---
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
  assign prdata = (paddr[2] == REG_CAPACITY) ? {{(CFG_DATA_W - 16){1'b0}}, cap_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr) begin
      cap_r <= pwdata[15:0];
    end
  end

  // --- input register ---
  assign room     = count_r <= ROOM_LIM;
  assign proc     = in_vld_r && room;
  assign in_stall = in_vld_r && !room;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_acc)    in_vld_nxt = 1'b1;
    else if (proc) in_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) in_byte_r <= in_byte;
  end

  // --- decode step ---
  urlpd_step u_step (
    .st_i  (st_r),
    .c_i   (in_byte_r),
    .cap_i (cap_r),
    .st_o  (st_nxt),
    .res_o (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= STATE_CLEAR;
    end else if (proc) begin
      st_r <= st_nxt;
    end
  end

  // --- result queue ---
  assign head      = mem[rd_ptr_r];
  assign out_valid = count_r != '0;
  assign out_byte  = head.data;
  assign out_last  = head.last;
  assign pop       = out_valid && !out_stall;
  assign count_nxt = count_r + CNT_W'(proc ? res.num : 2'd0) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (proc && res.num != 2'd0) mem[wr_ptr_r] <= res.item0;
    if (proc && res.num == 2'd2) mem[wr_ptr_r + PTR_W'(1)] <= res.item1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (proc) wr_ptr_r <= wr_ptr_r + PTR_W'(res.num);
      if (pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      count_r <= count_nxt;
    end
  end

  // --- checks ---
  `ASSERT_CLK(a_queue_bound, count_r <= DEPTH_C, "result queue overfilled")
  `ASSERT_CLK(a_stopped_quiet, (proc && st_r.stopped) |-> (res.num == 2'd0),
              "result produced after stop")
  `ASSERT_CLK(a_term_ends, (proc && res.num != 2'd0 &&
              ((res.num == 2'd1) ? res.item0.last : res.item1.last))
              |=> (st_r.stopped || st_r.count == 16'h0000),
              "terminator left string state open")
  `ASSERT_ANY(a_reset_empty, !rst_n |=> (count_r == '0 && !in_vld_r),
              "queue not empty after reset")

endmodule

// File: hw/rtl/urlpd_step.sv
// Per-item decode step: current state and one byte in, next state and up to
// two result items out. Purely combinational; depends on urlpd_pkg.
module urlpd_step (
  input  urlpd_pkg::dec_state_t st_i,
  input  logic [7:0]            c_i,
  input  logic [15:0]           cap_i,
  output urlpd_pkg::dec_state_t st_o,
  output urlpd_pkg::step_res_t  res_o
);
  import urlpd_pkg::*;

  logic [15:0] cnt_inc;
  logic        over;
  logic        full_inc;
  logic        is_nul;
  logic        is_pct;
  logic [7:0]  dec_byte;
  logic [7:0]  d1;
  logic [7:0]  d2;

  assign cnt_inc  = st_i.count + 16'd1;
  assign over     = st_i.count >= cap_i;
  assign full_inc = cnt_inc >= cap_i;
  assign is_nul   = c_i == CHAR_NUL;
  assign is_pct   = c_i == CHAR_PCT;
  assign d1       = digit_value(st_i.held);
  assign d2       = digit_value(c_i);
  // second digit is ORed in at full width
  assign dec_byte = {d1[3:0], 4'h0} | d2;

  // next state
  always_comb begin
    st_o = st_i;
    priority if (st_i.stopped) begin
      if (is_nul) st_o = STATE_CLEAR;
    end else if (over) begin
      if (is_nul) begin
        st_o = STATE_CLEAR;
      end else begin
        st_o.stopped = 1'b1;
        st_o.phase   = PH_IDLE;
      end
    end else if (is_nul) begin
      st_o = STATE_CLEAR;
    end else begin
      unique case (st_i.phase)
        PH_PCT: begin
          st_o.held  = c_i;
          st_o.phase = PH_DIG;
        end
        PH_DIG: begin
          st_o.phase   = PH_IDLE;
          st_o.count   = cnt_inc;
          st_o.stopped = full_inc;
        end
        default: begin
          if (is_pct) begin
            st_o.phase = PH_PCT;
          end else begin
            st_o.phase   = PH_IDLE;
            st_o.count   = cnt_inc;
            st_o.stopped = full_inc;
          end
        end
      endcase
    end
  end

  // result items; a terminator, when produced, always sits in the last used slot
  always_comb begin
    res_o.num   = 2'd0;
    res_o.item0 = ITEM_NONE;
    res_o.item1 = ITEM_TERM;
    priority if (st_i.stopped) begin
      res_o.num = 2'd0;
    end else if (over) begin
      res_o.num   = 2'd1;
      res_o.item0 = ITEM_TERM;
    end else if (is_nul) begin
      // string ends with one digit held: the percent is dropped
      if (st_i.phase == PH_DIG && st_i.held != CHAR_PCT) begin
        res_o.num   = 2'd2;
        res_o.item0 = '{data: plain_char(st_i.held), last: 1'b0};
      end else begin
        res_o.num   = 2'd1;
        res_o.item0 = ITEM_TERM;
      end
    end else begin
      unique case (st_i.phase)
        PH_PCT: res_o.num = 2'd0;
        PH_DIG: begin
          res_o.num   = full_inc ? 2'd2 : 2'd1;
          res_o.item0 = '{data: dec_byte, last: 1'b0};
        end
        default: begin
          if (!is_pct) begin
            res_o.num   = full_inc ? 2'd2 : 2'd1;
            res_o.item0 = '{data: plain_char(c_i), last: 1'b0};
          end
        end
      endcase
    end
  end

endmodule
